// ===== rtl/mcdl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcdl_pkg: shared definitions for the multichannel delay line
// Sizes, field widths, action codes and the store access request types.
// ---------------------------------------------------------------------------
package mcdl_pkg;

  localparam int DEPTH    = 1024;
  localparam int CHANNELS = 2;

  localparam int SAMPLE_W = 32;
  localparam int DELAY_W  = 11;
  localparam int CH_W     = 1;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int ADDR_W   = $clog2(CHANNELS * DEPTH);

  typedef enum logic {
    ACT_PUSH  = 1'b0,
    ACT_CLEAR = 1'b1
  } action_e;

  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic    en;
    addr_t   addr;
    sample_t data;
  } wr_req_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

endpackage : mcdl_pkg
`default_nettype wire

// ===== rtl/mcdl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcdl_if: channel interfaces of the multichannel delay line
// Input item, result and configuration write channels, valid/ready each.
// ---------------------------------------------------------------------------
interface mcdl_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic               channel;
  logic signed [31:0] sample_in;

  modport source (output valid, action, channel, sample_in, input ready);
  modport sink   (input valid, action, channel, sample_in, output ready);
endinterface : mcdl_in_if

interface mcdl_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] delayed_sample;

  modport source (output valid, delayed_sample, input ready);
  modport sink   (input valid, delayed_sample, output ready);
endinterface : mcdl_out_if

interface mcdl_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] delay_amount;

  modport source (output valid, delay_amount, input ready);
  modport sink   (input valid, delay_amount, output ready);
endinterface : mcdl_cfg_if
`default_nettype wire

// ===== rtl/mcdl_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcdl_store: sample memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module mcdl_store (
  input  logic             clk_i,
  input  mcdl_pkg::wr_req_t wr_i,
  input  mcdl_pkg::rd_req_t rd_i,
  output mcdl_pkg::sample_t rdata_o
);
  import mcdl_pkg::*;

  sample_t mem_q [CHANNELS*DEPTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // old data on a same-address collision; the controller bypasses that case
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule : mcdl_store
`default_nettype wire

// ===== rtl/mcdl_modsub.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcdl_modsub: modular index subtractor
// Returns (a - b) mod DEPTH for a, b below DEPTH.
// ---------------------------------------------------------------------------
module mcdl_modsub (
  input  mcdl_pkg::idx_t a_i,
  input  mcdl_pkg::idx_t b_i,
  output mcdl_pkg::idx_t res_o
);
  import mcdl_pkg::*;

  logic [IDX_W:0] wrapped;

  assign wrapped = {1'b0, a_i} + (IDX_W+1)'(DEPTH) - {1'b0, b_i};
  assign res_o   = (a_i >= b_i) ? (a_i - b_i) : wrapped[IDX_W-1:0];

endmodule : mcdl_modsub
`default_nettype wire

// ===== rtl/mcdl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mcdl_ctrl: sequencer of the delay line
// Runs the reset sweep, push access and clear walk, drives the store and
// holds the write positions and the result register.
// ---------------------------------------------------------------------------
module mcdl_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     action_i,
  input  logic [mcdl_pkg::CH_W-1:0] channel_i,
  input  mcdl_pkg::sample_t        sample_i,
  input  logic [mcdl_pkg::DELAY_W-1:0] delay_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mcdl_pkg::sample_t        out_data_o,
  output mcdl_pkg::wr_req_t        wr_o,
  output mcdl_pkg::rd_req_t        rd_o,
  input  mcdl_pkg::sample_t        rdata_i
);
  import mcdl_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PUSH,
    S_DATA,
    S_CLEAR
  } state_e;

  state_e            state_q;
  addr_t             init_q;
  logic [CH_W-1:0]   ch_q;
  sample_t           sample_q;
  idx_t              mag_q;
  idx_t              idx_q;
  idx_t              cnt_q;
  idx_t              wp_q [CHANNELS];
  logic              bypass_q;
  logic              out_valid_q;
  sample_t           out_data_q;

  logic              accept;
  logic [DELAY_W-1:0] mag_raw;
  idx_t              mag_sat;
  idx_t              sub_b;
  idx_t              sub_res;
  idx_t              wp_next;

  function automatic addr_t flat_addr(logic [CH_W-1:0] ch, idx_t idx);
    return ADDR_W'(int'(ch) * DEPTH + int'(idx));
  endfunction

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // magnitude of the signed delay, saturated to DEPTH-1
  assign mag_raw = delay_i[DELAY_W-1] ? (DELAY_W'(0) - delay_i) : delay_i;
  assign mag_sat = (32'(mag_raw) > 32'(DEPTH - 1)) ? IDX_W'(DEPTH - 1) : IDX_W'(mag_raw);

  // shared subtractor: read index on push, step back one on clear
  assign sub_b = (state_q == S_CLEAR) ? IDX_W'(1) : mag_q;

  mcdl_modsub u_modsub (
    .a_i   (idx_q),
    .b_i   (sub_b),
    .res_o (sub_res)
  );

  assign wp_next = (idx_q == IDX_W'(DEPTH - 1)) ? '0 : idx_q + IDX_W'(1);

  always_comb begin
    wr_o = '0;
    rd_o = '0;
    case (state_q)
      S_INIT: begin
        wr_o.en   = 1'b1;
        wr_o.addr = init_q;
      end
      S_PUSH: begin
        wr_o.en   = 1'b1;
        wr_o.addr = flat_addr(ch_q, idx_q);
        wr_o.data = sample_q;
        rd_o.en   = 1'b1;
        rd_o.addr = flat_addr(ch_q, sub_res);
      end
      S_CLEAR: begin
        wr_o.en   = 1'b1;
        wr_o.addr = flat_addr(ch_q, sub_res);
      end
      default: begin
        wr_o = '0;
        rd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wp_q[i] <= '0;
      end
    end else begin
      // the data stage owns the result valid while it runs
      if (out_ready_i && (state_q != S_DATA)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          init_q <= init_q + ADDR_W'(1);
          if (init_q == ADDR_W'(CHANNELS * DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && (int'(channel_i) < CHANNELS)) begin
            ch_q     <= channel_i;
            sample_q <= sample_i;
            mag_q    <= mag_sat;
            cnt_q    <= mag_sat;
            idx_q    <= wp_q[channel_i];
            if (action_i == ACT_PUSH) begin
              state_q <= S_PUSH;
            end else if (mag_sat != '0) begin
              state_q <= S_CLEAR;
            end
          end
        end
        S_PUSH: begin
          wp_q[ch_q] <= wp_next;
          bypass_q   <= (mag_q == '0);
          state_q    <= S_DATA;
        end
        S_DATA: begin
          // hold here while the previous result beat is still waiting
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= bypass_q ? sample_q : rdata_i;
            state_q     <= S_IDLE;
          end
        end
        S_CLEAR: begin
          idx_q <= sub_res;
          cnt_q <= cnt_q - IDX_W'(1);
          if (cnt_q == IDX_W'(1)) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_clear_writes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (wr_o.en && wr_o.data == '0))
    else $error("clear walk wrote a nonzero sample");

  a_clear_count_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (cnt_q != '0))
    else $error("clear walk running with zero count");

  a_result_from_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DATA))
    else $error("result raised outside the data stage");

  a_push_advances_wp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |=> (wp_q[$past(ch_q)] == $past(wp_next)))
    else $error("write position not advanced after push");

endmodule : mcdl_ctrl
`default_nettype wire

// ===== rtl/multichannel_delay_line.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// multichannel_delay_line: per-channel circular delay line
// Signed 32-bit samples, one ring of DEPTH entries per channel.
// ---------------------------------------------------------------------------
//  port     dir   beat
//  in_if    sink  action, channel, sample_in
//  out_if   src   delayed_sample (push only)
//  cfg_if   sink  delay_amount, always ready
//
//  Push: accept, then the access state (one memory write and read), then the
//  data state, which registers the result and returns to idle. Clear: one zero
//  write per cycle through the shared index subtractor, |delay| writes in all,
//  saturated to DEPTH-1. After reset a sweep over all CHANNELS*DEPTH (2048)
//  entries zeroes the memory; no item is accepted meanwhile.
//  A push whose result finds the output register still full waits for it.
// ---------------------------------------------------------------------------
module multichannel_delay_line (
  input  logic         clk_i,
  input  logic         rst_ni,
  mcdl_in_if.sink      in_if,
  mcdl_out_if.source   out_if,
  mcdl_cfg_if.sink     cfg_if
);
  import mcdl_pkg::*;

  logic [DELAY_W-1:0] delay_q;
  wr_req_t            wr;
  rd_req_t            rd;
  sample_t            rdata;
  sample_t            out_data;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
    end else if (cfg_if.valid && cfg_if.ready) begin
      delay_q <= cfg_if.delay_amount;
    end
  end

  mcdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .action_i    (in_if.action),
    .channel_i   (in_if.channel),
    .sample_i    (in_if.sample_in),
    .delay_i     (delay_q),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_data),
    .wr_o        (wr),
    .rd_o        (rd),
    .rdata_i     (rdata)
  );

  mcdl_store u_store (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rdata)
  );

  assign out_if.delayed_sample = out_data;

endmodule : multichannel_delay_line
`default_nettype wire
